FILE: hw/rtl/load_average_decay_update_core_assert.svh
// ----------------------------------------------------------------------------
// load_average_decay_update_core_assert.svh
// Assertion macros for the load-average decay RTL, used by ladu_back.
// ----------------------------------------------------------------------------
`ifndef LOAD_AVERAGE_DECAY_UPDATE_CORE_ASSERT_SVH
`define LOAD_AVERAGE_DECAY_UPDATE_CORE_ASSERT_SVH

// same-cycle implication
`define LADU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LADU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ladu_pkg.sv
// ----------------------------------------------------------------------------
// ladu_pkg
// Types, constants and the decay table of the load-average decay block.
// ----------------------------------------------------------------------------
package ladu_pkg;

    localparam int TASK_W      = 4;
    localparam int WEIGHT_W    = 17;
    localparam int PERIODS_W   = 12;
    localparam int SUM_W       = 32;
    localparam int AVG_W       = 17;
    localparam int COEF_W      = 16;

    localparam int MAX_TASKS_DEF       = 16;
    localparam int MAX_DECAY_SPANS_DEF = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam int HALF_LIFE    = 32;
    // coarse shift of 32 or more clears the sum
    localparam int COARSE_LIMIT = HALF_LIFE * SUM_W;
    localparam int Q_SHIFT      = 15;
    localparam logic [2:0] TBL_LAST = 3'd7;

    localparam int AVG_DIV     = 47742;
    localparam int RECIP_SHIFT = 34;
    localparam int AVG_RECIP_W = 19;
    localparam longint unsigned AVG_RECIP_FULL = (64'd1 << RECIP_SHIFT) / AVG_DIV;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(AVG_RECIP_FULL);

    typedef struct packed {
        logic                in_range;
        logic                kill;
        logic [4:0]          coarse;
        logic                fine_en;
        logic [2:0]          idx;
        logic [1:0]          frac;
        logic [TASK_W-1:0]   task_req;
        logic [WEIGHT_W-1:0] weight;
        logic                runnable;
    } ladu_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_INTERP,
        S_ACC,
        S_AVG_MUL,
        S_AVG_RECIP,
        S_DONE
    } state_t;

    // Q15 2^(-k/8)
    function automatic logic [COEF_W-1:0] decay_coef(input logic [2:0] k);
        logic [COEF_W-1:0] c;
        unique case (k)
            3'd0:    c = 16'd32768;
            3'd1:    c = 16'd30048;
            3'd2:    c = 16'd27554;
            3'd3:    c = 16'd25268;
            3'd4:    c = 16'd23170;
            3'd5:    c = 16'd21247;
            3'd6:    c = 16'd19484;
            3'd7:    c = 16'd17867;
            default: c = 16'd32768;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/ladu_if.sv
// ----------------------------------------------------------------------------
// ladu_if
// Valid/ready channels for update requests and results.
// ----------------------------------------------------------------------------
interface ladu_req_if;
    logic                          valid;
    logic                          ready;
    logic [ladu_pkg::TASK_W-1:0]   task_req;
    logic [ladu_pkg::WEIGHT_W-1:0] weight;
    logic                          runnable;
    logic [ladu_pkg::PERIODS_W-1:0] periods;

    modport source (output valid, task_req, weight, runnable, periods, input ready);
    modport sink   (input valid, task_req, weight, runnable, periods, output ready);
endinterface

interface ladu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ladu_pkg::SUM_W-1:0] new_sum;
    logic [ladu_pkg::AVG_W-1:0] average;

    modport source (output valid, new_sum, average, input ready);
    modport sink   (input valid, new_sum, average, output ready);
endinterface

FILE: hw/rtl/ladu_ram.sv
// ----------------------------------------------------------------------------
// ladu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ladu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/ladu_fifo.sv
// ----------------------------------------------------------------------------
// ladu_fifo
// Short queue between the classifying front and the update engine.
// ----------------------------------------------------------------------------
module ladu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign ready   = (count_reg != CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hw/rtl/ladu_front.sv
// ----------------------------------------------------------------------------
// ladu_front
// Accepts request beats and classifies the decay span into kill, coarse
// shift and table step.
// ----------------------------------------------------------------------------
module ladu_front #(
    parameter int MAX_TASKS       = ladu_pkg::MAX_TASKS_DEF,
    parameter int MAX_DECAY_SPANS = ladu_pkg::MAX_DECAY_SPANS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ladu_req_if.sink             req,
    output logic                 item_valid,
    output ladu_pkg::ladu_item_t item,
    input  logic                 item_ready
);

    localparam int LW = ladu_pkg::PERIODS_W + 1;
    localparam int TW = 9;
    localparam logic [LW-1:0] SPAN_LIMIT  = LW'(MAX_DECAY_SPANS * ladu_pkg::HALF_LIFE);
    localparam logic [LW-1:0] SHIFT_LIMIT = LW'(ladu_pkg::COARSE_LIMIT);

    logic                 hold_valid_reg, hold_valid_next;
    ladu_pkg::ladu_item_t item_reg;
    ladu_pkg::ladu_item_t item_next;
    logic                 accept;
    logic [LW-1:0]        p_ext;

    assign req.ready  = !hold_valid_reg || item_ready;
    assign accept     = req.valid && req.ready;
    assign item_valid = hold_valid_reg;
    assign item       = item_reg;
    assign p_ext      = LW'(req.periods);

    always_comb
    begin
        item_next.in_range = (TW'(req.task_req) < TW'(MAX_TASKS));
        item_next.kill     = (p_ext >= SPAN_LIMIT) || (p_ext >= SHIFT_LIMIT);
        item_next.coarse   = req.periods[9:5];
        item_next.fine_en  = (req.periods[4:0] != 5'd0);
        item_next.idx      = req.periods[4:2];
        item_next.frac     = req.periods[1:0];
        item_next.task_req = req.task_req;
        item_next.weight   = req.weight;
        item_next.runnable = req.runnable;
    end

    assign hold_valid_next = accept || (hold_valid_reg && !item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/ladu_back.sv
// ----------------------------------------------------------------------------
// ladu_back
// Update engine: reads the stored sum, decays it, adds the weight, writes
// it back and forms the capped average.
// ----------------------------------------------------------------------------
`include "load_average_decay_update_core_assert.svh"

module ladu_back #(
    parameter int MAX_TASKS = ladu_pkg::MAX_TASKS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fifo_valid,
    input  ladu_pkg::ladu_item_t fifo_item,
    output logic                 fifo_pop,
    ladu_rsp_if.source           rsp
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW = ladu_pkg::SUM_W;
    localparam int WW = ladu_pkg::WEIGHT_W;
    localparam int PRW = SW + ladu_pkg::COEF_W;
    localparam int PPW = WW + 16;
    localparam int RPW = PPW + ladu_pkg::AVG_RECIP_W;
    localparam int RS  = ladu_pkg::RECIP_SHIFT;
    localparam int QS  = ladu_pkg::Q_SHIFT;

    ladu_pkg::state_t     state_reg, state_next;
    ladu_pkg::ladu_item_t item_reg;
    logic [2**AW-1:0]     valid_reg;
    logic                 vld_rd_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SW-1:0]        out_sum_reg;
    logic [WW-1:0]        out_avg_reg;

    logic [SW-1:0]        ram_rdata;
    logic [SW-1:0]        shift_reg, dec_reg, sum_reg;
    logic [PRW-1:0]       prod_a_reg, prod_b_reg;
    logic                 cap_reg;
    logic [PPW-1:0]       prod_p_reg;
    logic [WW-1:0]        q_est_reg;

    logic                 ram_re, ram_we, out_load;
    logic [AW-1:0]        rd_addr, wr_addr;

    logic [SW-1:0]        b_val, n_val, d_val, c_val, lerp_val, dec_val, sat_val;
    logic [SW+1:0]        df_val;
    logic [SW:0]          acc_val;
    logic [RPW-1:0]       recip_prod;
    logic [PPW-1:0]       qd_val, rem_val;
    logic [WW:0]          q_fix;
    logic [WW-1:0]        avg_val;

    assign rd_addr = AW'(fifo_item.task_req);
    assign wr_addr = AW'(item_reg.task_req);

    ladu_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_TASKS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (sat_val),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ladu_pkg::S_IDLE:
            begin
                if (fifo_valid)
                begin
                    state_next = ladu_pkg::S_LOAD;
                end
            end
            ladu_pkg::S_LOAD:      state_next = ladu_pkg::S_MUL;
            ladu_pkg::S_MUL:       state_next = ladu_pkg::S_INTERP;
            ladu_pkg::S_INTERP:    state_next = ladu_pkg::S_ACC;
            ladu_pkg::S_ACC:       state_next = ladu_pkg::S_AVG_MUL;
            ladu_pkg::S_AVG_MUL:   state_next = ladu_pkg::S_AVG_RECIP;
            ladu_pkg::S_AVG_RECIP: state_next = ladu_pkg::S_DONE;
            ladu_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ladu_pkg::S_IDLE;
                end
            end
            default:               state_next = ladu_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        fifo_pop = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ladu_pkg::S_IDLE:
            begin
                fifo_pop = fifo_valid;
                ram_re   = fifo_valid && fifo_item.in_range;
            end
            ladu_pkg::S_ACC:
            begin
                ram_we = item_reg.in_range;
            end
            ladu_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                fifo_pop = 1'b0;
            end
        endcase
    end

    // table interpolation
    always_comb
    begin
        b_val    = prod_a_reg[QS+SW-1:QS];
        n_val    = prod_b_reg[QS+SW-1:QS];
        d_val    = (b_val >= n_val) ? (b_val - n_val) : '0;
        df_val   = (item_reg.frac[0] ? (SW+2)'(d_val) : '0)
                 + (item_reg.frac[1] ? (SW+2)'({d_val, 1'b0}) : '0);
        c_val    = df_val[SW+1:2];
        lerp_val = (b_val >= c_val) ? (b_val - c_val) : '0;
        priority if (!item_reg.fine_en)
        begin
            dec_val = shift_reg;
        end
        else if (item_reg.frac == 2'd0)
        begin
            dec_val = b_val;
        end
        else if (item_reg.idx == ladu_pkg::TBL_LAST)
        begin
            dec_val = b_val >> 1;
        end
        else
        begin
            dec_val = lerp_val;
        end
    end

    assign acc_val = (SW+1)'(dec_reg) + (item_reg.runnable ? (SW+1)'(item_reg.weight) : '0);
    assign sat_val = acc_val[SW] ? '1 : acc_val[SW-1:0];

    assign recip_prod = RPW'(prod_p_reg) * RPW'(ladu_pkg::AVG_RECIP);
    assign qd_val     = PPW'(q_est_reg) * PPW'(ladu_pkg::AVG_DIV);
    assign rem_val    = prod_p_reg - qd_val;
    assign q_fix      = (rem_val >= PPW'(ladu_pkg::AVG_DIV)) ? ((WW+1)'(q_est_reg) + 1'b1)
                                                            : (WW+1)'(q_est_reg);
    assign avg_val    = (cap_reg || (q_fix >= (WW+1)'(item_reg.weight))) ? item_reg.weight
                                                                        : q_fix[WW-1:0];

    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ladu_pkg::S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            item_reg   <= fifo_item;
            vld_rd_reg <= fifo_item.in_range && valid_reg[rd_addr];
        end
        if (state_reg == ladu_pkg::S_LOAD)
        begin
            shift_reg <= (item_reg.kill || !vld_rd_reg) ? '0 : (ram_rdata >> item_reg.coarse);
        end
        if (state_reg == ladu_pkg::S_MUL)
        begin
            prod_a_reg <= PRW'(shift_reg) * PRW'(ladu_pkg::decay_coef(item_reg.idx));
            prod_b_reg <= PRW'(shift_reg) * PRW'(ladu_pkg::decay_coef(item_reg.idx + 3'd1));
        end
        if (state_reg == ladu_pkg::S_INTERP)
        begin
            dec_reg <= dec_val;
        end
        if (state_reg == ladu_pkg::S_ACC)
        begin
            sum_reg <= sat_val;
            cap_reg <= (sat_val >= SW'(ladu_pkg::AVG_DIV));
        end
        if (state_reg == ladu_pkg::S_AVG_MUL)
        begin
            prod_p_reg <= PPW'(item_reg.weight) * PPW'(sum_reg[15:0]);
        end
        if (state_reg == ladu_pkg::S_AVG_RECIP)
        begin
            q_est_reg <= recip_prod[RS+WW-1:RS];
        end
        if (out_load)
        begin
            out_sum_reg <= item_reg.in_range ? sum_reg : '0;
            out_avg_reg <= item_reg.in_range ? avg_val : '0;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.new_sum = out_sum_reg;
    assign rsp.average = out_avg_reg;

    `LADU_ASSERT_IMP(a_write_in_range, clk, rst_n, ram_we, item_reg.in_range, "store write for task out of range")
    `LADU_ASSERT_NXT(a_pop_loads, clk, rst_n, fifo_pop, state_reg == ladu_pkg::S_LOAD, "pop did not start a load")
    `LADU_ASSERT_IMP(a_avg_capped, clk, rst_n, out_load, avg_val <= item_reg.weight, "average above weight")
    `LADU_ASSERT_NXT(a_kill_clears, clk, rst_n, (state_reg == ladu_pkg::S_LOAD) && item_reg.kill, shift_reg == '0, "killed sum not cleared")

endmodule

FILE: hw/rtl/load_average_decay_update_core.sv
// ----------------------------------------------------------------------------
// load_average_decay_update_core
// Per-task load sum decay, accumulation and capped average.
// ----------------------------------------------------------------------------
// req carries one update beat: task_req, weight, runnable, periods.
// rsp returns one beat per request: new_sum and average, in request order.
// A front stage registers and classifies each request into a two-entry
// queue; the update engine works on one request at a time.
// The engine takes a new request only after it is through with the last
// one: its sequence is store read, table multiply, interpolate, accumulate
// and write back, weight multiply, reciprocal multiply and correction.
// Requests keep being accepted until the queue and front stage are full.
// A stalled rsp holds its beat; the engine waits with the next result
// and the queue fills behind it.
// Reset clears every stored sum at once (per-task valid bits), empties
// the queue and drops any pending result.
// ----------------------------------------------------------------------------
module load_average_decay_update_core #(
    parameter int MAX_TASKS       = ladu_pkg::MAX_TASKS_DEF,
    parameter int MAX_DECAY_SPANS = ladu_pkg::MAX_DECAY_SPANS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ladu_req_if.sink   req,
    ladu_rsp_if.source rsp
);

    localparam int IW = $bits(ladu_pkg::ladu_item_t);

    logic                 front_valid, front_ready;
    ladu_pkg::ladu_item_t front_item;
    logic                 q_valid, q_pop;
    logic [IW-1:0]        q_data;
    ladu_pkg::ladu_item_t q_item;

    ladu_front #(
        .MAX_TASKS       (MAX_TASKS),
        .MAX_DECAY_SPANS (MAX_DECAY_SPANS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    ladu_fifo #(
        .WIDTH (IW),
        .DEPTH (ladu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .din   (front_item),
        .ready (front_ready),
        .pop   (q_pop),
        .dout  (q_data),
        .valid (q_valid)
    );

    assign q_item = ladu_pkg::ladu_item_t'(q_data);

    ladu_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (q_valid),
        .fifo_item  (q_item),
        .fifo_pop   (q_pop),
        .rsp        (rsp)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for load_average_decay_update_core. A scoreboard
// keeps its own copy of the per-task load sums, predicts new_sum and the
// capped average for every accepted request beat, and checks each result
// beat in order. Directed corner cases run first, then random traffic with
// bursts of idling on both channels, then a back-to-back run with no idling.
// ----------------------------------------------------------------------------
module testbench;

    import ladu_pkg::*;

    localparam int NUM_TASKS   = MAX_TASKS_DEF;
    localparam int DECAY_SPANS = MAX_DECAY_SPANS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 900;
    localparam int FILL_ITEMS  = 50;
    localparam int DRAIN_WAIT  = 30;

    typedef struct {
        logic [SUM_W-1:0] new_sum;
        logic [AVG_W-1:0] average;
    } load_result_t;

    class load_scoreboard;
        logic [SUM_W-1:0]  sums [NUM_TASKS];
        logic [COEF_W-1:0] decay_q15 [8];
        load_result_t      expected_q [$];
        int                errors;

        function new();
            decay_q15 = '{16'd32768, 16'd30048, 16'd27554, 16'd25268,
                          16'd23170, 16'd21247, 16'd19484, 16'd17867};
            foreach (sums[i]) sums[i] = '0;
            errors = 0;
        endfunction

        function logic [63:0] decayed(input logic [63:0] v, input int unsigned p);
            int unsigned coarse, rem, i, f;
            logic [63:0] b, n, d, c;
            if (p == 0) return v;
            if (p >= DECAY_SPANS * HALF_LIFE) return 64'd0;
            coarse = p / HALF_LIFE;
            if (coarse >= 32) return 64'd0;
            v = v >> coarse;
            rem = p % HALF_LIFE;
            if (rem == 0) return v;
            i = rem / 4;
            f = rem % 4;
            b = (v * 64'(decay_q15[i])) >> Q_SHIFT;
            if (f > 0)
            begin
                if (i < 7)
                begin
                    n = (v * 64'(decay_q15[i+1])) >> Q_SHIFT;
                    d = (b >= n) ? b - n : 64'd0;
                    c = (d * 64'(f)) / 4;
                    b = (b >= c) ? b - c : 64'd0;
                end
                else
                begin
                    b = b >> 1;
                end
            end
            return b;
        endfunction

        function void note_update(input logic [TASK_W-1:0] t, input logic [WEIGHT_W-1:0] w,
                                  input logic r, input logic [PERIODS_W-1:0] p);
            logic [63:0]  s, avg;
            load_result_t res;
            if (int'(t) >= NUM_TASKS)
            begin
                res.new_sum = '0;
                res.average = '0;
            end
            else
            begin
                s = decayed({32'd0, sums[t]}, 32'(p));
                if (r) s = s + 64'(w);
                if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
                sums[t] = s[SUM_W-1:0];
                avg = ({47'd0, w} * s) / AVG_DIV;
                if (avg > 64'(w)) avg = 64'(w);
                res.new_sum = s[SUM_W-1:0];
                res.average = avg[AVG_W-1:0];
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(input logic [SUM_W-1:0] s, input logic [AVG_W-1:0] a);
            load_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: new_sum %0d average %0d", $time, s, a);
                return;
            end
            exp_res = expected_q.pop_front();
            if (s !== exp_res.new_sum)
            begin
                errors++;
                $display("%0t new_sum mismatch: expected %0d actual %0d",
                         $time, exp_res.new_sum, s);
            end
            if (a !== exp_res.average)
            begin
                errors++;
                $display("%0t average mismatch: expected %0d actual %0d",
                         $time, exp_res.average, a);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   cycles;

    ladu_req_if req_ch ();
    ladu_rsp_if rsp_ch ();

    load_scoreboard sb;

    load_average_decay_update_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t timeout after %0d cycles", $time, cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // beat monitor
    initial
    begin
        sb = new();
        forever
        begin
            @(posedge clk);
            if (rst_n && req_ch.valid && req_ch.ready)
                sb.note_update(req_ch.task_req, req_ch.weight, req_ch.runnable, req_ch.periods);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.new_sum, rsp_ch.average);
        end
    end

    // result backpressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                rsp_ch.ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    task automatic send_update(input logic [TASK_W-1:0] t, input logic [WEIGHT_W-1:0] w,
                               input logic r, input logic [PERIODS_W-1:0] p);
        @(negedge clk);
        req_ch.valid    = 1'b1;
        req_ch.task_req = t;
        req_ch.weight   = w;
        req_ch.runnable = r;
        req_ch.periods  = p;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic idle_req(input int n);
        @(negedge clk);
        req_ch.valid    = 1'b0;
        req_ch.task_req = TASK_W'($urandom);
        req_ch.weight   = WEIGHT_W'($urandom);
        req_ch.runnable = 1'($urandom);
        req_ch.periods  = PERIODS_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 5) == 0)
            idle_req($urandom_range(1, 12));
    endtask

    task automatic send_random();
        logic [WEIGHT_W-1:0]  w;
        logic [PERIODS_W-1:0] p;
        int                   pick;
        if ($urandom_range(0, 9) == 0)
            w = WEIGHT_W'($urandom);
        else
            w = WEIGHT_W'($urandom_range(0, 88761));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            p = PERIODS_W'($urandom_range(0, 63));
        else if (pick < 9)
            p = PERIODS_W'($urandom_range(64, 1100));
        else
            p = PERIODS_W'($urandom);
        send_update(TASK_W'($urandom_range(0, NUM_TASKS - 1)), w,
                    $urandom_range(0, 4) != 0, p);
    endtask

    initial
    begin
        quiet           = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.task_req = '0;
        req_ch.weight   = '0;
        req_ch.runnable = 1'b0;
        req_ch.periods  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // table steps, interpolation, halving past the last entry, coarse shifts
        send_update(4'd0, 17'd88761, 1'b1, 12'd0);
        send_update(4'd0, 17'd0, 1'b1, 12'd1);
        send_update(4'd0, 17'd1024, 1'b1, 12'd3);
        send_update(4'd0, 17'd1000, 1'b1, 12'd4);
        send_update(4'd0, 17'd500, 1'b1, 12'd7);
        send_update(4'd0, 17'd2, 1'b0, 12'd29);
        send_update(4'd0, 17'd88761, 1'b1, 12'd28);
        send_update(4'd0, 17'd3, 1'b1, 12'd32);
        send_update(4'd0, 17'h1FFFF, 1'b1, 12'd33);
        send_update(4'd0, 17'd88761, 1'b1, 12'd1023);
        send_update(4'd1, 17'h1FFFF, 1'b1, 12'd0);
        send_update(4'd1, 17'd77777, 1'b1, 12'd1024);
        send_update(4'd1, 17'd88761, 1'b1, 12'd2047);
        send_update(4'd1, 17'd5, 1'b1, 12'd2048);
        send_update(4'd1, 17'd1, 1'b0, 12'hFFF);
        send_update(4'd2, 17'h1FFFF, 1'b1, 12'd0);
        send_update(4'd2, 17'd0, 1'b0, 12'd0);
        send_update(4'd15, 17'd88761, 1'b1, 12'd0);
        send_update(4'd15, 17'd1, 1'b1, 12'd31);
        send_update(4'd3, 17'd1, 1'b1, 12'd0);
        send_update(4'd3, 17'd15, 1'b1, 12'd2);

        repeat (RAND_ITEMS)
        begin
            maybe_idle();
            send_random();
        end

        // back-to-back accumulation into one task, then random traffic with no idling
        quiet = 1'b1;
        repeat (FILL_ITEMS) send_update(4'd9, 17'h1FFFF, 1'b1, 12'd0);
        send_update(4'd9, 17'd88761, 1'b0, 12'd1);
        send_update(4'd9, 17'd88761, 1'b1, 12'd31);
        send_update(4'd9, 17'h1FFFF, 1'b1, 12'd0);
        repeat (20) send_random();
        idle_req(1);

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
